// ===== rtl/rtfvd_pkg.sv =====
// Package for the rule table field value decoder.
// Holds the widths, rule kind and status codes, and the word types that pass along the chain.
// No dependencies.
package rtfvd_pkg;

  // Default parameter values.
  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF     = 16;

  // Fixed field widths.
  localparam int unsigned CODE_W     = 32;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned OUT_W      = 48;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CW_W       = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Limits of the 48-bit signed result.
  localparam logic signed [63:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] OUT_MIN = 64'shFFFF_8000_0000_0000;

  typedef enum logic [2:0] {
    KIND_ILLEGAL   = 3'd0,
    KIND_UNDEFINED = 3'd1,
    KIND_LINEAR    = 3'd2,
    KIND_BOUNDED   = 3'd3,
    KIND_UNBOUNDED = 3'd4,
    KIND_EXACT     = 3'd5,
    KIND_UNUSED    = 3'd6
  } rule_kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ILLEGAL   = 3'd1,
    ST_UNDEFINED = 3'd2,
    ST_NOSTMT    = 3'd3,
    ST_NOMATCH   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_CODE_WIDTH     = 2'd0,
    CFG_MSB_AT_HIGHEST = 2'd1,
    CFG_NOSTMT_EN      = 2'd2,
    CFG_NOSTMT_CODE    = 2'd3
  } cfg_reg_e;

  // First hit of each rule kind, gathered as a word walks the chain.
  typedef struct packed {
    logic                    ill;
    logic                    und;
    logic                    lin;
    logic                    bnd;
    logic                    unb;
    logic                    exa;
    logic [CODE_W-1:0]       lin_low;
    logic signed [VAL_W-1:0] lin_base;
    logic signed [VAL_W-1:0] lin_step;
    logic signed [VAL_W-1:0] bnd_base;
    logic signed [VAL_W-1:0] unb_base;
  } match_t;

  // One word in flight: either a table write or a decode request.
  typedef struct packed {
    logic                    is_write;
    logic [IDX_W-1:0]        wr_index;
    rule_kind_e              wr_kind;
    logic [CODE_W-1:0]       wr_low;
    logic [CODE_W-1:0]       wr_high;
    logic signed [VAL_W-1:0] wr_base;
    logic signed [VAL_W-1:0] wr_step;
    logic [CODE_W-1:0]       code_value;
    logic                    nostmt;
    match_t                  hits;
  } chain_word_t;

  // Decoded result word.
  typedef struct packed {
    status_e                 status;
    logic signed [OUT_W-1:0] value;
    logic [CODE_W-1:0]       code_value;
    logic                    sat;
  } result_t;

endpackage

// ===== rtl/rtfvd_in_if.sv =====
// Input channel of the rule table field value decoder: valid/ready plus one request word.
// Depends on rtfvd_pkg for the field widths.
interface rtfvd_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     action;
  logic [rtfvd_pkg::CODE_W-1:0]             code;
  logic [rtfvd_pkg::IDX_W-1:0]              entry_index;
  logic [rtfvd_pkg::KIND_W-1:0]             entry_kind;
  logic [rtfvd_pkg::CODE_W-1:0]             entry_low;
  logic [rtfvd_pkg::CODE_W-1:0]             entry_high;
  logic signed [rtfvd_pkg::VAL_W-1:0]       entry_base;
  logic signed [rtfvd_pkg::VAL_W-1:0]       entry_step;

  modport source (
    output valid, action, code, entry_index, entry_kind, entry_low, entry_high,
           entry_base, entry_step,
    input  ready
  );

  modport sink (
    input  valid, action, code, entry_index, entry_kind, entry_low, entry_high,
           entry_base, entry_step,
    output ready
  );
endinterface

// ===== rtl/rtfvd_out_if.sv =====
// Output channel of the rule table field value decoder: valid/ready plus one result word.
// Depends on rtfvd_pkg for the field widths.
interface rtfvd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [rtfvd_pkg::STATUS_W-1:0]       status;
  logic signed [rtfvd_pkg::OUT_W-1:0]   value;
  logic [rtfvd_pkg::CODE_W-1:0]         code_value;
  logic                                 value_saturated;

  modport source (
    output valid, status, value, code_value, value_saturated,
    input  ready
  );

  modport sink (
    input  valid, status, value, code_value, value_saturated,
    output ready
  );
endinterface

// ===== rtl/rule_table_field_value_decoder.sv =====
// Rule table field value decoder, top level.
// Depends on rtfvd_pkg, rtfvd_in_if, rtfvd_out_if, rtfvd_cell and rtfvd_resolve.
//
// Usage:
//   in_i carries request words. action 1 writes one rule table entry and gives no
//   result; action 0 decodes code and gives exactly one result word on out_o.
//   The configuration port writes code_width, msb_at_highest, no_statement_enable
//   and no_statement_code by index; write it only while no word is in flight.
//   Pipeline: a decode accepted on in_i passes one input stage, one stage per
//   table cell, a multiply stage and the output register on its way to out_o.
//   Throughput: one word per cycle; the whole cell chain moves as one pipeline.
//   Table writes travel down the chain in order, so a decode sees every write
//   accepted before it and none accepted after it.
//   Stall: while out_o holds a word that is not taken, the chain freezes and
//   in_i.ready is low; ready returns in the cycle the word is taken.
//   Reset: every table entry becomes unused, configuration returns to a 32-bit
//   code with no reversal and no no-statement code, and the pipeline empties.
module rule_table_field_value_decoder #(
  parameter int unsigned TABLE_ENTRIES = rtfvd_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned FRAC_BITS     = rtfvd_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  rtfvd_in_if.sink                             in_i,
  rtfvd_out_if.source                          out_o,
  input  logic                                 cfg_we_i,
  input  logic [rtfvd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rtfvd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  logic [rtfvd_pkg::CW_W-1:0]     code_width_q;
  logic                           msb_at_highest_q;
  logic                           nostmt_en_q;
  logic [rtfvd_pkg::CODE_W-1:0]   nostmt_code_q;

  logic                           adv;
  logic [rtfvd_pkg::CW_W-1:0]     code_w;
  logic [rtfvd_pkg::CODE_W-1:0]   mask;
  logic [rtfvd_pkg::CODE_W-1:0]   raw;
  logic [rtfvd_pkg::CODE_W-1:0]   rev;
  rtfvd_pkg::chain_word_t         prep_d;

  logic                           chain_valid [TABLE_ENTRIES+1];
  rtfvd_pkg::chain_word_t         chain_word  [TABLE_ENTRIES+1];

  logic                           res_valid;
  rtfvd_pkg::result_t             res;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_width_q     <= 6'd32;
      msb_at_highest_q <= 1'b0;
      nostmt_en_q      <= 1'b0;
      nostmt_code_q    <= '0;
    end else if (cfg_we_i) begin
      case (rtfvd_pkg::cfg_reg_e'(cfg_index_i))
        rtfvd_pkg::CFG_CODE_WIDTH:     code_width_q     <= cfg_data_i[5:0];
        rtfvd_pkg::CFG_MSB_AT_HIGHEST: msb_at_highest_q <= cfg_data_i[0];
        rtfvd_pkg::CFG_NOSTMT_EN:      nostmt_en_q      <= cfg_data_i[0];
        rtfvd_pkg::CFG_NOSTMT_CODE:    nostmt_code_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The whole chain moves whenever the output register is free or being emptied.
  assign adv        = !res_valid || out_o.ready;
  assign in_i.ready = adv;

  // Effective width: zero acts as one, anything above 32 as 32.
  always_comb begin
    if (code_width_q == 6'd0) begin
      code_w = 6'd1;
    end else if (code_width_q > 6'd32) begin
      code_w = 6'd32;
    end else begin
      code_w = code_width_q;
    end
  end

  // Cut the code to width, optionally reverse it, and build the word for the chain.
  always_comb begin
    mask = (code_w >= 6'd32) ? '1 : ((32'd1 << code_w) - 32'd1);
    raw  = in_i.code & mask;
    for (int b = 0; b < 32; b++) begin
      rev[b] = raw[31-b];
    end
    prep_d            = '0;
    prep_d.is_write   = in_i.action;
    prep_d.wr_index   = in_i.entry_index;
    prep_d.wr_kind    = (in_i.entry_kind > 3'(rtfvd_pkg::KIND_EXACT)) ?
                        rtfvd_pkg::KIND_UNUSED : rtfvd_pkg::rule_kind_e'(in_i.entry_kind);
    prep_d.wr_low     = in_i.entry_low;
    prep_d.wr_high    = in_i.entry_high;
    prep_d.wr_base    = in_i.entry_base;
    prep_d.wr_step    = in_i.entry_step;
    prep_d.code_value = msb_at_highest_q ? (rev >> (6'd32 - code_w)) : raw;
    prep_d.nostmt     = nostmt_en_q && (raw == (nostmt_code_q & mask));
  end

  // Input stage at the head of the chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_valid[0] <= 1'b0;
    end else if (adv) begin
      chain_valid[0] <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      chain_word[0] <= prep_d;
    end
  end

  // Chain of rule cells, one per table slot.
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    rtfvd_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (chain_valid[g]),
      .word_i  (chain_word[g]),
      .valid_o (chain_valid[g+1]),
      .word_o  (chain_word[g+1])
    );
  end

  // Precedence, arithmetic and output register.
  rtfvd_resolve #(
    .FRAC_BITS (FRAC_BITS)
  ) u_resolve (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (chain_valid[TABLE_ENTRIES]),
    .word_i   (chain_word[TABLE_ENTRIES]),
    .valid_o  (res_valid),
    .result_o (res)
  );

  assign out_o.valid           = res_valid;
  assign out_o.status          = res.status;
  assign out_o.value           = res.value;
  assign out_o.code_value      = res.code_value;
  assign out_o.value_saturated = res.sat;

  // Clipping only ever happens on a decoded value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.value_saturated |-> out_o.status == rtfvd_pkg::ST_OK)
    else $error("saturation flagged on a word that was not decoded");

  // Words that were not decoded carry a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != rtfvd_pkg::ST_OK |-> out_o.value == 48'sd0)
    else $error("non-zero value on a word that was not decoded");

  // The no-statement status needs the feature switched on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == rtfvd_pkg::ST_NOSTMT |-> nostmt_en_q)
    else $error("no-statement status while the code is disabled");

  // The corrected code never reaches beyond the configured width.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.code_value >> code_w) == 32'd0)
    else $error("code value wider than the configured code width");

endmodule

// ===== rtl/rtfvd_cell.sv =====
// One cell of the rule chain: holds a single rule table entry and compares each passing word.
// Depends on rtfvd_pkg for the word and kind types.
module rtfvd_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   valid_i,
  input  rtfvd_pkg::chain_word_t word_i,
  output logic                   valid_o,
  output rtfvd_pkg::chain_word_t word_o
);

  rtfvd_pkg::rule_kind_e                kind_q;
  logic [rtfvd_pkg::CODE_W-1:0]         low_q;
  logic [rtfvd_pkg::CODE_W-1:0]         high_q;
  logic signed [rtfvd_pkg::VAL_W-1:0]   base_q;
  logic signed [rtfvd_pkg::VAL_W-1:0]   step_q;
  logic                                 valid_q;
  rtfvd_pkg::chain_word_t               word_q;
  rtfvd_pkg::chain_word_t               word_d;
  logic                                 wr_hit;
  logic                                 dec;
  logic                                 in_range;
  logic                                 eq_low;

  // Compare the passing code against this entry; only the first hit of a kind is kept.
  always_comb begin
    wr_hit   = valid_i && word_i.is_write && (32'(word_i.wr_index) == CELL_IDX);
    dec      = valid_i && !word_i.is_write;
    in_range = (word_i.code_value >= low_q) && (word_i.code_value <= high_q);
    eq_low   = (word_i.code_value == low_q);
    word_d   = word_i;
    if (dec) begin
      case (kind_q)
        rtfvd_pkg::KIND_ILLEGAL: begin
          if (in_range) word_d.hits.ill = 1'b1;
        end
        rtfvd_pkg::KIND_UNDEFINED: begin
          if (in_range) word_d.hits.und = 1'b1;
        end
        rtfvd_pkg::KIND_LINEAR: begin
          if (in_range && !word_i.hits.lin) begin
            word_d.hits.lin      = 1'b1;
            word_d.hits.lin_low  = low_q;
            word_d.hits.lin_base = base_q;
            word_d.hits.lin_step = step_q;
          end
        end
        rtfvd_pkg::KIND_BOUNDED: begin
          if (eq_low && !word_i.hits.bnd) begin
            word_d.hits.bnd      = 1'b1;
            word_d.hits.bnd_base = base_q;
          end
        end
        rtfvd_pkg::KIND_UNBOUNDED: begin
          if (eq_low && !word_i.hits.unb) begin
            word_d.hits.unb      = 1'b1;
            word_d.hits.unb_base = base_q;
          end
        end
        rtfvd_pkg::KIND_EXACT: begin
          if (eq_low) word_d.hits.exa = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Entry kind; every slot starts out unused.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= rtfvd_pkg::KIND_UNUSED;
    end else if (adv_i && wr_hit) begin
      kind_q <= word_i.wr_kind;
    end
  end

  // Entry payload, written together with the kind.
  always_ff @(posedge clk_i) begin
    if (adv_i && wr_hit) begin
      low_q  <= word_i.wr_low;
      high_q <= word_i.wr_high;
      base_q <= word_i.wr_base;
      step_q <= word_i.wr_step;
    end
  end

  // Hand the word on to the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== rtl/rtfvd_resolve.sv =====
// Result stage of the decoder: applies the kind precedence, the linear multiply and saturation.
// Depends on rtfvd_pkg; fed by the last cell of the chain.
module rtfvd_resolve #(
  parameter int unsigned FRAC_BITS = rtfvd_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   valid_i,
  input  rtfvd_pkg::chain_word_t word_i,
  output logic                   valid_o,
  output rtfvd_pkg::result_t     result_o
);

  logic [rtfvd_pkg::CODE_W-1:0]         off;
  logic signed [rtfvd_pkg::CODE_W:0]    off_s;
  logic signed [64:0]                   prod;
  logic [63:0]                          exs;
  rtfvd_pkg::status_e                   a_status_d;
  logic                                 a_lin_d;
  logic signed [rtfvd_pkg::OUT_W-1:0]   a_val_d;
  logic                                 a_sat_d;

  logic                                 a_valid_q;
  rtfvd_pkg::status_e                   a_status_q;
  logic                                 a_lin_q;
  logic signed [rtfvd_pkg::OUT_W-1:0]   a_val_q;
  logic                                 a_sat_q;
  logic signed [63:0]                   a_prod_q;
  logic signed [rtfvd_pkg::VAL_W-1:0]   a_base_q;
  logic [rtfvd_pkg::CODE_W-1:0]         a_code_q;

  logic signed [64:0]                   sum;
  rtfvd_pkg::result_t                   res_d;
  rtfvd_pkg::result_t                   res_q;
  logic                                 out_valid_q;

  // First stage: pick the winning kind by precedence and form the linear product.
  always_comb begin
    off        = word_i.code_value - word_i.hits.lin_low;
    off_s      = $signed({1'b0, off});
    prod       = off_s * $signed(word_i.hits.lin_step);
    exs        = 64'(word_i.code_value) << FRAC_BITS;
    a_lin_d    = 1'b0;
    a_val_d    = '0;
    a_sat_d    = 1'b0;
    if (word_i.hits.ill) begin
      a_status_d = rtfvd_pkg::ST_ILLEGAL;
    end else if (word_i.hits.und) begin
      a_status_d = rtfvd_pkg::ST_UNDEFINED;
    end else if (word_i.hits.lin) begin
      a_status_d = rtfvd_pkg::ST_OK;
      a_lin_d    = 1'b1;
    end else if (word_i.hits.bnd) begin
      a_status_d = rtfvd_pkg::ST_OK;
      a_val_d    = 48'($signed(word_i.hits.bnd_base));
    end else if (word_i.hits.unb) begin
      a_status_d = rtfvd_pkg::ST_OK;
      a_val_d    = 48'($signed(word_i.hits.unb_base));
    end else if (word_i.hits.exa) begin
      a_status_d = rtfvd_pkg::ST_OK;
      if (exs > 64'(rtfvd_pkg::OUT_MAX)) begin
        a_val_d = rtfvd_pkg::OUT_MAX[47:0];
        a_sat_d = 1'b1;
      end else begin
        a_val_d = exs[47:0];
      end
    end else if (word_i.nostmt) begin
      a_status_d = rtfvd_pkg::ST_NOSTMT;
    end else begin
      a_status_d = rtfvd_pkg::ST_NOMATCH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv_i) begin
      a_valid_q <= valid_i && !word_i.is_write;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_status_q <= a_status_d;
      a_lin_q    <= a_lin_d;
      a_val_q    <= a_val_d;
      a_sat_q    <= a_sat_d;
      a_prod_q   <= prod[63:0];
      a_base_q   <= word_i.hits.lin_base;
      a_code_q   <= word_i.code_value;
    end
  end

  // Second stage: add the linear base and clip to the 48-bit range.
  always_comb begin
    sum              = 65'(a_base_q) + 65'(a_prod_q);
    res_d.status     = a_status_q;
    res_d.code_value = a_code_q;
    res_d.value      = a_val_q;
    res_d.sat        = a_sat_q;
    if (a_lin_q) begin
      if (sum > 65'(rtfvd_pkg::OUT_MAX)) begin
        res_d.value = rtfvd_pkg::OUT_MAX[47:0];
        res_d.sat   = 1'b1;
      end else if (sum < 65'(rtfvd_pkg::OUT_MIN)) begin
        res_d.value = rtfvd_pkg::OUT_MIN[47:0];
        res_d.sat   = 1'b1;
      end else begin
        res_d.value = sum[47:0];
        res_d.sat   = 1'b0;
      end
    end
  end

  // Output register; holds its word while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = out_valid_q;
  assign result_o = res_q;

endmodule

// ===== dv/rule_table_field_value_decoder_tb.sv =====
// Self-checking testbench for the rule table field value decoder.
// Depends on rtfvd_pkg, rtfvd_in_if, rtfvd_out_if and rule_table_field_value_decoder;
// a scoreboard class predicts each decode word and checks the results in order.
`timescale 1ns / 100ps

module rule_table_field_value_decoder_tb;
  import rtfvd_pkg::*;

  localparam int unsigned N_SLOTS      = TABLE_ENTRIES_DEF;
  localparam int unsigned FRAC         = FRAC_BITS_DEF;
  localparam int unsigned DRAIN_CYCLES = TABLE_ENTRIES_DEF + 2 + 6;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned IDLE_PCT     = 34;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned N_PHASES     = 12;
  localparam int unsigned PHASE_WORDS  = 140;

  // Kind code seven is outside the enum; the block must store it as unused.
  localparam logic [KIND_W-1:0] KIND_RESERVED = 3'd7;

  localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh8000_0000;

  // One request word as it crosses the input channel.
  typedef struct packed {
    logic                    action;
    logic [CODE_W-1:0]       code;
    logic [IDX_W-1:0]        slot;
    logic [KIND_W-1:0]       kind;
    logic [CODE_W-1:0]       lo;
    logic [CODE_W-1:0]       hi;
    logic signed [VAL_W-1:0] base;
    logic signed [VAL_W-1:0] incr;
  } request_t;

  // Scoreboard: keeps its own rule table and settings, and the decode results
  // still awaited from the block in acceptance order.
  class field_value_scoreboard;
    rule_kind_e              kinds[N_SLOTS];
    logic [CODE_W-1:0]       lows[N_SLOTS];
    logic [CODE_W-1:0]       highs[N_SLOTS];
    logic signed [VAL_W-1:0] bases[N_SLOTS];
    logic signed [VAL_W-1:0] steps[N_SLOTS];
    logic [CW_W-1:0]         code_width;
    logic                    reverse_bits;
    logic                    nostmt_en;
    logic [CODE_W-1:0]       nostmt_code;
    result_t                 awaited_results[$];
    int                      errors;

    function new();
      for (int i = 0; i < N_SLOTS; i++) begin
        kinds[i] = KIND_UNUSED;
        lows[i]  = '0;
        highs[i] = '0;
        bases[i] = '0;
        steps[i] = '0;
      end
      code_width   = CW_W'(CODE_W);
      reverse_bits = 1'b0;
      nostmt_en    = 1'b0;
      nostmt_code  = '0;
      errors       = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CODE_WIDTH:     code_width   = data[CW_W-1:0];
        CFG_MSB_AT_HIGHEST: reverse_bits = data[0];
        CFG_NOSTMT_EN:      nostmt_en    = data[0];
        CFG_NOSTMT_CODE:    nostmt_code  = data[CODE_W-1:0];
        default: ;
      endcase
    endfunction

    // Width zero behaves as one bit, anything above the code width as the full code.
    function int unsigned active_width();
      if (code_width == 0) return 1;
      if (code_width > CODE_W) return CODE_W;
      return code_width;
    endfunction

    function logic [CODE_W-1:0] width_mask();
      int unsigned w;
      w = active_width();
      return (w == CODE_W) ? '1 : ((32'd1 << w) - 32'd1);
    endfunction

    function logic [CODE_W-1:0] reverse_within(logic [CODE_W-1:0] c, int unsigned w);
      logic [CODE_W-1:0] r;
      r = '0;
      for (int unsigned b = 0; b < w; b++) begin
        if (c[b]) r[w-1-b] = 1'b1;
      end
      return r;
    endfunction

    // Lowest slot of the given kind holding the code, or -1.
    function int first_hit(rule_kind_e k, logic [CODE_W-1:0] c, bit ranged);
      for (int i = 0; i < N_SLOTS; i++) begin
        if (kinds[i] == k) begin
          if (ranged ? (c >= lows[i] && c <= highs[i]) : (c == lows[i])) return i;
        end
      end
      return -1;
    endfunction

    // Works out the result word for one decode under the present table and settings.
    function result_t decode_field(logic [CODE_W-1:0] code);
      int unsigned       w;
      logic [CODE_W-1:0] mask, raw, c;
      int                ill, und, lin, bnd, unb, exa;
      longint            off, sx;
      result_t           res;
      w    = active_width();
      mask = width_mask();
      raw  = code & mask;
      c    = reverse_bits ? reverse_within(raw, w) : raw;
      ill  = first_hit(KIND_ILLEGAL, c, 1'b1);
      und  = first_hit(KIND_UNDEFINED, c, 1'b1);
      lin  = first_hit(KIND_LINEAR, c, 1'b1);
      bnd  = first_hit(KIND_BOUNDED, c, 1'b0);
      unb  = first_hit(KIND_UNBOUNDED, c, 1'b0);
      exa  = first_hit(KIND_EXACT, c, 1'b0);
      res.status     = ST_NOMATCH;
      res.value      = '0;
      res.code_value = c;
      res.sat        = 1'b0;
      sx             = 0;
      if (ill >= 0) begin
        res.status = ST_ILLEGAL;
      end else if (und >= 0) begin
        res.status = ST_UNDEFINED;
      end else if (lin >= 0) begin
        // Offset below 2^32 times a 32-bit step cannot leave 64 bits.
        off = longint'({32'd0, c - lows[lin]});
        sx  = longint'(bases[lin]) + off * longint'(steps[lin]);
        if (sx > OUT_MAX) begin
          sx      = OUT_MAX;
          res.sat = 1'b1;
        end
        if (sx < OUT_MIN) begin
          sx      = OUT_MIN;
          res.sat = 1'b1;
        end
        res.status = ST_OK;
      end else if (bnd >= 0) begin
        sx         = longint'(bases[bnd]);
        res.status = ST_OK;
      end else if (unb >= 0) begin
        sx         = longint'(bases[unb]);
        res.status = ST_OK;
      end else if (exa >= 0) begin
        sx = longint'({32'd0, c}) <<< FRAC;
        if (sx > OUT_MAX) begin
          sx      = OUT_MAX;
          res.sat = 1'b1;
        end
        res.status = ST_OK;
      end else if (nostmt_en && raw == (nostmt_code & mask)) begin
        res.status = ST_NOSTMT;
      end
      res.value = sx[OUT_W-1:0];
      return res;
    endfunction

    // Called for every accepted request word.
    function void note_request(request_t r);
      if (r.action) begin
        kinds[r.slot] = (r.kind > KIND_EXACT) ? KIND_UNUSED : rule_kind_e'(r.kind);
        lows[r.slot]  = r.lo;
        highs[r.slot] = r.hi;
        bases[r.slot] = r.base;
        steps[r.slot] = r.incr;
      end else begin
        awaited_results.push_back(decode_field(r.code));
      end
    endfunction

    task report_mismatch(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
    endtask

    // Called for every accepted result word.
    task check_result(logic [STATUS_W-1:0] st, logic signed [OUT_W-1:0] val,
                      logic [CODE_W-1:0] cv, logic sat);
      result_t want;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing awaited, status %0d code %h", st, cv));
        return;
      end
      want = awaited_results.pop_front();
      if (st !== want.status)
        report_mismatch($sformatf("code %h status %0d, want %0d", want.code_value, st,
                                  want.status));
      if (val !== want.value)
        report_mismatch($sformatf("code %h value %h, want %h", want.code_value, val,
                                  want.value));
      if (cv !== want.code_value)
        report_mismatch($sformatf("code value %h, want %h", cv, want.code_value));
      if (sat !== want.sat)
        report_mismatch($sformatf("code %h saturated %b, want %b", want.code_value, sat,
                                  want.sat));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  calm;
  logic                  hold_output;
  int unsigned           cycle_count;

  field_value_scoreboard sb = new();

  rtfvd_in_if  in_if();
  rtfvd_out_if out_if();

  rule_table_field_value_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Give up if the run stalls.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("rule_table_field_value_decoder_tb: done, errors");
      $finish;
    end
  end

  // Watch both channels; predictions are made as request words are taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        sb.note_request(request_t'({in_if.action, in_if.code, in_if.entry_index,
                                    in_if.entry_kind, in_if.entry_low, in_if.entry_high,
                                    in_if.entry_base, in_if.entry_step}));
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.status, out_if.value, out_if.code_value,
                        out_if.value_saturated);
    end
  end

  // Result taker: random back-pressure, or a long hold when asked for one.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_output) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_output = 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  function automatic request_t rule_write(logic [IDX_W-1:0] slot, logic [KIND_W-1:0] kind,
                                          logic [CODE_W-1:0] lo, logic [CODE_W-1:0] hi,
                                          logic signed [VAL_W-1:0] base,
                                          logic signed [VAL_W-1:0] incr);
    request_t r;
    r.action = 1'b1;
    r.code   = $urandom;
    r.slot   = slot;
    r.kind   = kind;
    r.lo     = lo;
    r.hi     = hi;
    r.base   = base;
    r.incr   = incr;
    return r;
  endfunction

  function automatic request_t decode_req(logic [CODE_W-1:0] code);
    request_t r;
    r        = '0;
    r.code   = code;
    r.slot   = IDX_W'($urandom);
    r.kind   = KIND_W'($urandom);
    r.lo     = $urandom;
    r.hi     = $urandom;
    r.base   = $urandom;
    r.incr   = $urandom;
    return r;
  endfunction

  // Q16.16 value biased toward the extremes.
  function automatic logic signed [VAL_W-1:0] pick_q();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 12) return Q_MAX;
    if (sel < 24) return Q_MIN;
    if (sel < 40) return VAL_W'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    return $urandom;
  endfunction

  // A random rule, mostly with its codes inside the active width.
  function automatic request_t rule_random(logic [IDX_W-1:0] slot);
    logic [CODE_W-1:0] mask, lo, hi;
    logic [KIND_W-1:0] kind;
    int                sel;
    mask = sb.width_mask();
    sel  = $urandom_range(0, 99);
    if (sel < 10)      kind = KIND_ILLEGAL;
    else if (sel < 20) kind = KIND_UNDEFINED;
    else if (sel < 45) kind = KIND_LINEAR;
    else if (sel < 60) kind = KIND_BOUNDED;
    else if (sel < 72) kind = KIND_UNBOUNDED;
    else if (sel < 90) kind = KIND_EXACT;
    else if (sel < 95) kind = KIND_UNUSED;
    else               kind = KIND_RESERVED;
    lo  = ($urandom_range(0, 99) < 95) ? ($urandom & mask) : $urandom;
    sel = $urandom_range(0, 99);
    if (sel < 55)      hi = lo + $urandom_range(0, 24);
    else if (sel < 75) hi = lo + ($urandom & mask);
    else if (sel < 88) hi = lo - 1 - $urandom_range(0, 8);
    else               hi = mask;
    return rule_write(slot, kind, lo, hi, pick_q(), pick_q());
  endfunction

  // A code aimed near the rule edges, the no-statement code, or anywhere at all.
  function automatic logic [CODE_W-1:0] pick_code();
    logic [CODE_W-1:0] mask, c;
    int                sel, k;
    mask = sb.width_mask();
    sel  = $urandom_range(0, 99);
    k    = $urandom_range(0, N_SLOTS - 1);
    if (sel < 35)      c = sb.lows[k] + $urandom_range(0, 2) - 1;
    else if (sel < 55) c = sb.highs[k] + $urandom_range(0, 2) - 1;
    else if (sel < 65) c = sb.lows[k] + $urandom_range(0, 15);
    else if (sel < 72) c = ($urandom_range(0, 1) != 0) ? '1 : '0;
    else if (sel < 85) return (sb.nostmt_code & mask) | ($urandom & ~mask);
    else               return $urandom;
    c = c & mask;
    if (sb.reverse_bits) c = sb.reverse_within(c, sb.active_width());
    return c | ($urandom & ~mask);
  endfunction

  // Offers one word after a random gap and returns at the edge it is taken.
  task automatic send_request(request_t r);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.action      <= r.action;
    in_if.code        <= r.code;
    in_if.entry_index <= r.slot;
    in_if.entry_kind  <= r.kind;
    in_if.entry_low   <= r.lo;
    in_if.entry_high  <= r.hi;
    in_if.entry_base  <= r.base;
    in_if.entry_step  <= r.incr;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Waits for every awaited result, then lets trailing table writes leave the chain.
  task automatic wait_drained();
    while (sb.awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    sb.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic apply_settings(logic [CW_W-1:0] cw, logic rev, logic en,
                                logic [CODE_W-1:0] nsc, bit junk);
    write_reg(CFG_CODE_WIDTH, {junk ? 26'($urandom) : 26'd0, cw});
    write_reg(CFG_MSB_AT_HIGHEST, {junk ? 31'($urandom) : 31'd0, rev});
    write_reg(CFG_NOSTMT_EN, {junk ? 31'($urandom) : 31'd0, en});
    write_reg(CFG_NOSTMT_CODE, nsc);
    cfg_we_i <= 1'b0;
  endtask

  // Settings per phase: widths include zero and values above the code width.
  logic [CW_W-1:0] phase_width[N_PHASES] = '{32, 1, 0, 63, 8, 17, 40, 32, 24, 31, 12, 2};
  logic            phase_rev[N_PHASES]   = '{1, 0, 1, 1, 0, 1, 0, 0, 1, 1, 0, 1};
  logic            phase_en[N_PHASES]    = '{1, 1, 0, 1, 1, 0, 1, 1, 1, 0, 1, 1};

  initial begin
    request_t          directed[$];
    logic [CODE_W-1:0] nsc;
    int                sel;
    rst_ni            = 1'b0;
    calm              = 1'b0;
    hold_output       = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = CFG_CODE_WIDTH;
    cfg_data_i        = '0;
    in_if.valid       = 1'b0;
    in_if.action      = 1'b0;
    in_if.code        = '0;
    in_if.entry_index = '0;
    in_if.entry_kind  = '0;
    in_if.entry_low   = '0;
    in_if.entry_high  = '0;
    in_if.entry_base  = '0;
    in_if.entry_step  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under the reset settings: every kind, overlaps, precedence,
    // saturation both ways, an empty range and kind code seven.
    directed.push_back(rule_write(0, KIND_ILLEGAL, 100, 110, 0, 0));
    directed.push_back(rule_write(1, KIND_UNDEFINED, 105, 120, 0, 0));
    directed.push_back(rule_write(2, KIND_LINEAR, 32'h8000_0001, 32'hFFFF_FFFF, Q_MAX, Q_MAX));
    directed.push_back(rule_write(3, KIND_LINEAR, 32'h0000_1000, 32'h0FFF_FFFF, Q_MIN, Q_MIN));
    directed.push_back(rule_write(4, KIND_BOUNDED, 50, 0, Q_MIN, 0));
    directed.push_back(rule_write(5, KIND_UNBOUNDED, 60, 0, Q_MAX, 0));
    directed.push_back(rule_write(6, KIND_EXACT, 32'h8000_0000, 0, 0, 0));
    directed.push_back(rule_write(7, KIND_EXACT, 7, 0, 0, 0));
    directed.push_back(rule_write(8, KIND_RESERVED, 70, 70, 0, 0));
    directed.push_back(rule_write(9, KIND_ILLEGAL, 90, 80, 0, 0));
    directed.push_back(rule_write(10, KIND_LINEAR, 200, 300, 32'sh0000_8000, 32'shFFFF_C000));
    directed.push_back(rule_write(15, KIND_BOUNDED, 60, 60, 32'sh0001_8000, 0));
    directed.push_back(decode_req(32'h0000_0000));
    directed.push_back(decode_req(7));
    directed.push_back(decode_req(50));
    directed.push_back(decode_req(60));
    directed.push_back(decode_req(70));
    directed.push_back(decode_req(85));
    directed.push_back(decode_req(100));
    directed.push_back(decode_req(115));
    directed.push_back(decode_req(250));
    directed.push_back(decode_req(32'h8000_0000));
    directed.push_back(decode_req(32'h8000_0001));
    directed.push_back(decode_req(32'hFFFF_FFFF));
    directed.push_back(decode_req(32'h0FFF_FFFF));
    foreach (directed[i]) send_request(directed[i]);
    in_if.valid <= 1'b0;

    // Random phases: new settings, a fresh table, then mostly aimed decodes.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      if (ph == 1)      nsc = '0;
      else if (ph == 2) nsc = '1;
      else              nsc = $urandom;
      apply_settings(phase_width[ph], phase_rev[ph], phase_en[ph], nsc, (ph % 4) == 3);
      calm = (ph == 5);
      for (int s = 0; s < N_SLOTS; s++) send_request(rule_random(IDX_W'(s)));
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ((ph == 3 || ph == 8) && n == 20) hold_output = 1'b1;
        sel = $urandom_range(0, 99);
        if (sel < 88)      send_request(decode_req(pick_code()));
        else if (sel < 97) send_request(rule_random(IDX_W'($urandom_range(0, N_SLOTS - 1))));
        else               send_request(decode_req($urandom));
      end
      in_if.valid <= 1'b0;
    end
    calm = 1'b0;

    wait_drained();
    if (sb.errors == 0) begin
      $display("rule_table_field_value_decoder_tb: done, clean");
    end else begin
      $display("rule_table_field_value_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule
